// ===== hdl/jes_pkg.sv =====
// Shared constants, types and helper functions of the Jacobi eigen solver.
// No dependencies; used by jes_cordic, jacobi_eigen_solver, jes_checker and tb_top.
package jes_pkg;

    localparam int N       = 4;                  // matrix dimension
    localparam int IDX_W   = $clog2(N);          // row / column index width
    localparam int STEPS   = 24;                 // CORDIC iterations
    localparam int STEP_W  = 6;                  // holds any step count up to 32
    localparam int CW      = 40;                 // CORDIC datapath width
    localparam int ACC_W   = 38;                 // sum of up to three rounded products
    localparam int RND_W   = 36;                 // rounded a*b/2^30
    localparam int OUT_W   = 88;                 // result tdata width
    localparam int CFG_W   = 31;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROT   = 1'b1;

    localparam logic [30:0] TOL_RESET  = 31'd1;
    localparam logic [15:0] MAXR_RESET = 16'd5000;

    localparam logic signed [CW-1:0]  CORDIC_GAIN = 40'sd652032874;
    localparam logic signed [CW-1:0]  QUARTER_PI  = 40'sd843314857;
    localparam logic signed [31:0]    Q30_ONE     = 32'sd1073741824;
    localparam logic signed [65:0]    Q30_HALF    = 66'sd536870912;

    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [4:0] {
        ST_LOAD, ST_INIT, ST_SEARCH, ST_DECIDE, ST_RD_PP, ST_RD_QQ, ST_ANG,
        ST_ANG_WAIT, ST_SC_WAIT, ST_MAC, ST_DRAIN, ST_P_RDP, ST_P_RDQ, ST_P_WR,
        ST_A_RDP, ST_A_RDQ, ST_A_WR, ST_DIAG_WR, ST_OUT_LD, ST_OUT_SEND
    } state_t;

    typedef enum logic [2:0] {
        OPA_C, OPA_S, OPA_NS, OPA_CC, OPA_SS, OPA_SC, OPA_SC2, OPA_CMS
    } op_a_t;

    typedef enum logic [2:0] {
        OPB_C, OPB_S, OPB_VP, OPB_VQ, OPB_APP, OPB_APQ, OPB_AQQ, OPB_AQMAP
    } op_b_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_CC, DST_SS, DST_SC, DST_R1, DST_R2, DST_DPP, DST_DQQ, DST_DPQ
    } dst_t;

    typedef struct packed {
        op_a_t a;
        op_b_t b;
        logic  init_acc;
        logic  neg;
        dst_t  dst;
        logic  stop;
    } term_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_ctl_t;

    // microcode entry points
    localparam logic [3:0] PC_CS   = 4'd0;
    localparam logic [3:0] PC_VEC  = 4'd3;
    localparam logic [3:0] PC_DIAG = 4'd7;

    function automatic term_t mk(input op_a_t a, input op_b_t b, input logic i,
                                 input logic n, input dst_t d, input logic s);
        term_t t;
        t.a = a; t.b = b; t.init_acc = i; t.neg = n; t.dst = d; t.stop = s;
        return t;
    endfunction

    // product sequences: cos/sin squares, a vector pair, the 2x2 diagonal block
    function automatic term_t mac_term(input logic [3:0] pc);
        term_t t;
        unique case (pc)
            4'd0:    t = mk(OPA_C,   OPB_C,     1'b1, 1'b0, DST_CC,   1'b0);
            4'd1:    t = mk(OPA_S,   OPB_S,     1'b1, 1'b0, DST_SS,   1'b0);
            4'd2:    t = mk(OPA_S,   OPB_C,     1'b1, 1'b0, DST_SC,   1'b1);
            4'd3:    t = mk(OPA_C,   OPB_VP,    1'b1, 1'b0, DST_NONE, 1'b0);
            4'd4:    t = mk(OPA_S,   OPB_VQ,    1'b0, 1'b0, DST_R1,   1'b0);
            4'd5:    t = mk(OPA_NS,  OPB_VP,    1'b1, 1'b0, DST_NONE, 1'b0);
            4'd6:    t = mk(OPA_C,   OPB_VQ,    1'b0, 1'b0, DST_R2,   1'b1);
            4'd7:    t = mk(OPA_CC,  OPB_APP,   1'b1, 1'b0, DST_NONE, 1'b0);
            4'd8:    t = mk(OPA_SC2, OPB_APQ,   1'b0, 1'b0, DST_NONE, 1'b0);
            4'd9:    t = mk(OPA_SS,  OPB_AQQ,   1'b0, 1'b0, DST_DPP,  1'b0);
            4'd10:   t = mk(OPA_SS,  OPB_APP,   1'b1, 1'b0, DST_NONE, 1'b0);
            4'd11:   t = mk(OPA_SC2, OPB_APQ,   1'b0, 1'b1, DST_NONE, 1'b0);
            4'd12:   t = mk(OPA_CC,  OPB_AQQ,   1'b0, 1'b0, DST_DQQ,  1'b0);
            4'd13:   t = mk(OPA_CMS, OPB_APQ,   1'b1, 1'b0, DST_NONE, 1'b0);
            4'd14:   t = mk(OPA_SC,  OPB_AQMAP, 1'b0, 1'b0, DST_DPQ,  1'b1);
            default: t = mk(OPA_C,   OPB_C,     1'b1, 1'b0, DST_NONE, 1'b1);
        endcase
        return t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(64'sd2147483647))       return 32'sh7FFFFFFF;
        else if (v < -ACC_W'(64'sd2147483648)) return 32'sh80000000;
        else                                   return v[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_one(input logic signed [CW-1:0] v);
        if (v > CW'(Q30_ONE))       return Q30_ONE;
        else if (v < -CW'(Q30_ONE)) return -Q30_ONE;
        else                        return v[31:0];
    endfunction

endpackage

// ===== hdl/jes_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on jes_pkg.
module jes_cordic (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  jes_pkg::cordic_ctl_t              ctl,
    input  logic signed [jes_pkg::CW-1:0]     x_in,
    input  logic signed [jes_pkg::CW-1:0]     y_in,
    input  logic signed [jes_pkg::CW-1:0]     z_in,
    output logic                              done,
    output logic signed [jes_pkg::CW-1:0]     x_out,
    output logic signed [jes_pkg::CW-1:0]     y_out,
    output logic signed [jes_pkg::CW-1:0]     z_out
);

    logic signed [jes_pkg::CW-1:0] x_reg, y_reg, z_reg;
    logic signed [jes_pkg::CW-1:0] x_next, y_next, z_next, dx, dy, at;
    logic [jes_pkg::STEP_W-1:0]    step_reg;
    logic                          run_reg, done_reg, vec_reg, plus_x, last;

    always_comb begin
        dx     = y_reg >>> step_reg;
        dy     = x_reg >>> step_reg;
        at     = jes_pkg::CW'(jes_pkg::ATAN_TABLE[step_reg[4:0]]);
        // vectoring drives y to zero, rotation drives z to zero
        plus_x = vec_reg ? !y_reg[jes_pkg::CW-1] : z_reg[jes_pkg::CW-1];
        if (plus_x) begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end else begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end
        last = (step_reg == jes_pkg::STEP_W'(jes_pkg::STEPS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + 1'b1;
                if (last) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            x_reg   <= x_in;
            y_reg   <= y_in;
            z_reg   <= z_in;
            vec_reg <= ctl.vectoring;
        end else if (run_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== hdl/jacobi_eigen_solver.sv =====
// Classical Jacobi eigen solver: matrix store, search, shared multiplier and sequencer.
// Depends on jes_pkg and jes_cordic.
// Load: one beat per cycle, the first N*N beats are stored; the last beat starts the computation.
// Each rotation: a search over the N(N-1)/2 upper off-diagonal entries, one CORDIC pass
// (equal diagonal) or two, and product sequences on the single shared 33x33 multiplier.
// Output: N*N beats, each held until accepted; s_tready is low from the last beat until done.
// aresetn (synchronous, active low) clears control and config to 1 / 5000.
module jacobi_eigen_solver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // entry_value
    input  logic                          s_tlast,   // last_entry
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pair_index[2:0], component_index[5:3], eigenvalue[37:6],
    // vector_component[69:38], rotation_count[85:70], zero fill
    output logic [jes_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tlast,   // last_result
    input  logic                          cfg_wr_en,
    input  logic [jes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jes_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int N  = jes_pkg::N;
    localparam int IW = jes_pkg::IDX_W;
    localparam int CW = jes_pkg::CW;

    jes_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [IW-1:0] ld_row_reg, ld_row_next, ld_col_reg, ld_col_next;
    logic          ld_full_reg, ld_full_next;
    logic [IW-1:0] si_reg, si_next, sj_reg, sj_next, bp_reg, bp_next, bq_reg, bq_next;
    logic          sfirst_reg, sfirst_next;
    logic [IW-1:0] k_reg, k_next, oi_reg, oi_next, oj_reg, oj_next;
    logic [15:0]   rot_reg, rot_next, maxr_reg;
    logic [30:0]   tol_reg;
    logic [3:0]    pc_reg, pc_next;
    logic          mac_v_reg, mac_v_next, zero_den_reg, zero_den_next;
    logic          m_valid_reg, m_valid_next;

    logic signed [31:0] a_reg [N][N];
    logic signed [31:0] p_reg [N][N];
    logic signed [31:0] best_reg, app_reg, aqq_reg, c_reg, s_reg, cc_reg, ss_reg, sc_reg;
    logic signed [31:0] vp_reg, vq_reg, r1_reg, r2_reg, dpp_reg, dqq_reg, dpq_reg;
    logic signed [32:0] bmag_reg;
    logic signed [jes_pkg::RND_W-1:0] mul_reg;
    logic signed [jes_pkg::ACC_W-1:0] acc_reg, sum;
    jes_pkg::term_t term_d_reg, cur_term;
    logic [jes_pkg::OUT_W-1:0] m_data_reg;
    logic                      m_last_reg;

    logic [IW-1:0]      a_row, a_col, p_row, p_col;
    logic signed [31:0] a_rd, p_rd, cl_c, cl_s;
    logic signed [32:0] vmag, b_diff, a_dbl, opa, opb;
    logic signed [65:0] prod, prod_rnd;
    logic               take, s_acc;

    jes_pkg::cordic_ctl_t     cor_ctl;
    logic signed [CW-1:0]     cor_x_in, cor_y_in, cor_z_in, cor_x, cor_y, cor_z;
    logic                     cor_done;

    jes_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cor_ctl),
        .x_in    (cor_x_in),
        .y_in    (cor_y_in),
        .z_in    (cor_z_in),
        .done    (cor_done),
        .x_out   (cor_x),
        .y_out   (cor_y),
        .z_out   (cor_z)
    );

    // single read port on each store per cycle
    always_comb begin
        a_row = '0;
        a_col = '0;
        p_row = '0;
        p_col = '0;
        unique case (state_reg)
            jes_pkg::ST_SEARCH: begin a_row = si_reg; a_col = sj_reg; end
            jes_pkg::ST_RD_PP:  begin a_row = bp_reg; a_col = bp_reg; end
            jes_pkg::ST_RD_QQ:  begin a_row = bq_reg; a_col = bq_reg; end
            jes_pkg::ST_A_RDP:  begin a_row = k_reg;  a_col = bp_reg; end
            jes_pkg::ST_A_RDQ:  begin a_row = k_reg;  a_col = bq_reg; end
            jes_pkg::ST_P_RDP:  begin p_row = k_reg;  p_col = bp_reg; end
            jes_pkg::ST_P_RDQ:  begin p_row = k_reg;  p_col = bq_reg; end
            jes_pkg::ST_OUT_LD: begin
                a_row = oi_reg; a_col = oi_reg;
                p_row = oj_reg; p_col = oi_reg;
            end
            default: ;
        endcase
        a_rd = a_reg[a_row][a_col];
        p_rd = p_reg[p_row][p_col];
    end

    // shared multiplier, rounded half up at 2^-30
    always_comb begin
        cur_term = jes_pkg::mac_term(pc_reg);
        unique case (cur_term.a)
            jes_pkg::OPA_C:   opa = 33'(c_reg);
            jes_pkg::OPA_S:   opa = 33'(s_reg);
            jes_pkg::OPA_NS:  opa = -33'(s_reg);
            jes_pkg::OPA_CC:  opa = 33'(cc_reg);
            jes_pkg::OPA_SS:  opa = 33'(ss_reg);
            jes_pkg::OPA_SC:  opa = 33'(sc_reg);
            jes_pkg::OPA_SC2: opa = 33'(sc_reg) <<< 1;
            jes_pkg::OPA_CMS: opa = 33'(cc_reg) - 33'(ss_reg);
        endcase
        unique case (cur_term.b)
            jes_pkg::OPB_C:     opb = 33'(c_reg);
            jes_pkg::OPB_S:     opb = 33'(s_reg);
            jes_pkg::OPB_VP:    opb = 33'(vp_reg);
            jes_pkg::OPB_VQ:    opb = 33'(vq_reg);
            jes_pkg::OPB_APP:   opb = 33'(app_reg);
            jes_pkg::OPB_APQ:   opb = 33'(best_reg);
            jes_pkg::OPB_AQQ:   opb = 33'(aqq_reg);
            jes_pkg::OPB_AQMAP: opb = 33'(aqq_reg) - 33'(app_reg);
        endcase
        prod     = opa * opb;
        prod_rnd = prod + jes_pkg::Q30_HALF;
        s_acc    = term_d_reg.init_acc;
        sum      = s_acc ? '0 : acc_reg;
        if (term_d_reg.neg) sum = sum - jes_pkg::ACC_W'(mul_reg);
        else                sum = sum + jes_pkg::ACC_W'(mul_reg);
    end

    always_comb begin
        vmag   = a_rd[31] ? -33'(a_rd) : 33'(a_rd);
        take   = sfirst_reg || (vmag > bmag_reg);
        b_diff = 33'(app_reg) - 33'(aqq_reg);
        a_dbl  = 33'(best_reg) <<< 1;
        cl_c   = jes_pkg::clamp_one(cor_x);
        cl_s   = jes_pkg::clamp_one(cor_y);
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        ld_row_next   = ld_row_reg;
        ld_col_next   = ld_col_reg;
        ld_full_next  = ld_full_reg;
        si_next       = si_reg;
        sj_next       = sj_reg;
        sfirst_next   = sfirst_reg;
        bp_next       = bp_reg;
        bq_next       = bq_reg;
        k_next        = k_reg;
        oi_next       = oi_reg;
        oj_next       = oj_reg;
        rot_next      = rot_reg;
        pc_next       = pc_reg;
        zero_den_next = zero_den_reg;
        m_valid_next  = m_valid_reg;
        mac_v_next    = 1'b0;
        cor_ctl       = '0;
        cor_x_in      = jes_pkg::CORDIC_GAIN;
        cor_y_in      = '0;
        cor_z_in      = jes_pkg::QUARTER_PI;

        unique case (state_reg)
            jes_pkg::ST_LOAD: begin
                if (s_tvalid) begin
                    if (!ld_full_reg) begin
                        if (ld_col_reg == IW'(N - 1)) begin
                            ld_col_next = '0;
                            if (ld_row_reg == IW'(N - 1)) ld_full_next = 1'b1;
                            else ld_row_next = ld_row_reg + 1'b1;
                        end else begin
                            ld_col_next = ld_col_reg + 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        ld_row_next  = '0;
                        ld_col_next  = '0;
                        ld_full_next = 1'b0;
                        state_next   = jes_pkg::ST_INIT;
                    end
                end
            end
            jes_pkg::ST_INIT: begin
                rot_next    = '0;
                si_next     = '0;
                sj_next     = IW'(1);
                sfirst_next = 1'b1;
                state_next  = jes_pkg::ST_SEARCH;
            end
            jes_pkg::ST_SEARCH: begin
                sfirst_next = 1'b0;
                if (take) begin
                    bp_next = si_reg;
                    bq_next = sj_reg;
                end
                if (sj_reg == IW'(N - 1)) begin
                    if (si_reg == IW'(N - 2)) begin
                        state_next = jes_pkg::ST_DECIDE;
                    end else begin
                        si_next = si_reg + 1'b1;
                        sj_next = IW'(32'(si_reg) + 2);
                    end
                end else begin
                    sj_next = sj_reg + 1'b1;
                end
            end
            jes_pkg::ST_DECIDE: begin
                if ((bmag_reg > 33'(tol_reg)) && (rot_reg < maxr_reg)) begin
                    state_next = jes_pkg::ST_RD_PP;
                end else begin
                    oi_next    = '0;
                    oj_next    = '0;
                    state_next = jes_pkg::ST_OUT_LD;
                end
            end
            jes_pkg::ST_RD_PP: state_next = jes_pkg::ST_RD_QQ;
            jes_pkg::ST_RD_QQ: state_next = jes_pkg::ST_ANG;
            jes_pkg::ST_ANG: begin
                cor_ctl.start = 1'b1;
                if (b_diff == '0) begin
                    // equal diagonal: fixed angle of a quarter pi
                    zero_den_next = 1'b1;
                    state_next    = jes_pkg::ST_SC_WAIT;
                end else begin
                    zero_den_next     = 1'b0;
                    cor_ctl.vectoring = 1'b1;
                    cor_x_in = b_diff[32] ? -CW'(b_diff) : CW'(b_diff);
                    cor_y_in = b_diff[32] ? -CW'(a_dbl) : CW'(a_dbl);
                    cor_z_in = '0;
                    state_next = jes_pkg::ST_ANG_WAIT;
                end
            end
            jes_pkg::ST_ANG_WAIT: begin
                if (cor_done) begin
                    cor_ctl.start = 1'b1;
                    cor_z_in      = cor_z >>> 1;
                    state_next    = jes_pkg::ST_SC_WAIT;
                end
            end
            jes_pkg::ST_SC_WAIT: begin
                if (cor_done) begin
                    pc_next    = jes_pkg::PC_CS;
                    ret_next   = jes_pkg::ST_P_RDP;
                    k_next     = '0;
                    state_next = jes_pkg::ST_MAC;
                end
            end
            jes_pkg::ST_MAC: begin
                mac_v_next = 1'b1;
                if (cur_term.stop) state_next = jes_pkg::ST_DRAIN;
                else pc_next = pc_reg + 1'b1;
            end
            jes_pkg::ST_DRAIN: state_next = ret_reg;
            jes_pkg::ST_P_RDP: state_next = jes_pkg::ST_P_RDQ;
            jes_pkg::ST_P_RDQ: begin
                pc_next    = jes_pkg::PC_VEC;
                ret_next   = jes_pkg::ST_P_WR;
                state_next = jes_pkg::ST_MAC;
            end
            jes_pkg::ST_P_WR: begin
                if (k_reg == IW'(N - 1)) begin
                    k_next     = '0;
                    state_next = jes_pkg::ST_A_RDP;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = jes_pkg::ST_P_RDP;
                end
            end
            jes_pkg::ST_A_RDP: begin
                // rows p and q are covered by the diagonal block
                if (k_reg == bp_reg || k_reg == bq_reg) begin
                    if (k_reg == IW'(N - 1)) begin
                        pc_next    = jes_pkg::PC_DIAG;
                        ret_next   = jes_pkg::ST_DIAG_WR;
                        state_next = jes_pkg::ST_MAC;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    state_next = jes_pkg::ST_A_RDQ;
                end
            end
            jes_pkg::ST_A_RDQ: begin
                pc_next    = jes_pkg::PC_VEC;
                ret_next   = jes_pkg::ST_A_WR;
                state_next = jes_pkg::ST_MAC;
            end
            jes_pkg::ST_A_WR: begin
                if (k_reg == IW'(N - 1)) begin
                    pc_next    = jes_pkg::PC_DIAG;
                    ret_next   = jes_pkg::ST_DIAG_WR;
                    state_next = jes_pkg::ST_MAC;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = jes_pkg::ST_A_RDP;
                end
            end
            jes_pkg::ST_DIAG_WR: begin
                rot_next    = rot_reg + 1'b1;
                si_next     = '0;
                sj_next     = IW'(1);
                sfirst_next = 1'b1;
                state_next  = jes_pkg::ST_SEARCH;
            end
            jes_pkg::ST_OUT_LD: begin
                m_valid_next = 1'b1;
                state_next   = jes_pkg::ST_OUT_SEND;
            end
            jes_pkg::ST_OUT_SEND: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (oj_reg == IW'(N - 1)) begin
                        oj_next = '0;
                        if (oi_reg == IW'(N - 1)) begin
                            state_next = jes_pkg::ST_LOAD;
                        end else begin
                            oi_next    = oi_reg + 1'b1;
                            state_next = jes_pkg::ST_OUT_LD;
                        end
                    end else begin
                        oj_next    = oj_reg + 1'b1;
                        state_next = jes_pkg::ST_OUT_LD;
                    end
                end
            end
            default: state_next = jes_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= jes_pkg::ST_LOAD;
            ret_reg      <= jes_pkg::ST_LOAD;
            ld_row_reg   <= '0;
            ld_col_reg   <= '0;
            ld_full_reg  <= 1'b0;
            si_reg       <= '0;
            sj_reg       <= '0;
            sfirst_reg   <= 1'b0;
            bp_reg       <= '0;
            bq_reg       <= '0;
            k_reg        <= '0;
            oi_reg       <= '0;
            oj_reg       <= '0;
            rot_reg      <= '0;
            pc_reg       <= '0;
            zero_den_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            mac_v_reg    <= 1'b0;
            tol_reg      <= jes_pkg::TOL_RESET;
            maxr_reg     <= jes_pkg::MAXR_RESET;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            ld_row_reg   <= ld_row_next;
            ld_col_reg   <= ld_col_next;
            ld_full_reg  <= ld_full_next;
            si_reg       <= si_next;
            sj_reg       <= sj_next;
            sfirst_reg   <= sfirst_next;
            bp_reg       <= bp_next;
            bq_reg       <= bq_next;
            k_reg        <= k_next;
            oi_reg       <= oi_next;
            oj_reg       <= oj_next;
            rot_reg      <= rot_next;
            pc_reg       <= pc_next;
            zero_den_reg <= zero_den_next;
            m_valid_reg  <= m_valid_next;
            mac_v_reg    <= mac_v_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    jes_pkg::CFG_TOLERANCE: tol_reg  <= cfg_wr_data;
                    jes_pkg::CFG_MAX_ROT:   maxr_reg <= cfg_wr_data[15:0];
                endcase
            end
        end
    end

    // datapath registers and matrix stores
    always_ff @(posedge aclk) begin
        mul_reg    <= prod_rnd[65:30];
        term_d_reg <= cur_term;

        if (state_reg == jes_pkg::ST_LOAD && s_tvalid && !ld_full_reg)
            a_reg[ld_row_reg][ld_col_reg] <= s_tdata;

        if (state_reg == jes_pkg::ST_INIT) begin
            for (int i = 0; i < N; i++)
                for (int j = 0; j < N; j++)
                    p_reg[i][j] <= (i == j) ? jes_pkg::Q30_ONE : 32'sd0;
        end

        if (state_reg == jes_pkg::ST_SEARCH && take) begin
            best_reg <= a_rd;
            bmag_reg <= vmag;
        end

        if (state_reg == jes_pkg::ST_RD_PP) app_reg <= a_rd;
        if (state_reg == jes_pkg::ST_RD_QQ) aqq_reg <= a_rd;

        if (state_reg == jes_pkg::ST_SC_WAIT && cor_done) begin
            if (zero_den_reg && !(best_reg > 32'sd0)) begin
                // three quarter pi: quarter pi turned by a quarter turn
                c_reg <= -cl_s;
                s_reg <= cl_c;
            end else begin
                c_reg <= cl_c;
                s_reg <= cl_s;
            end
        end

        if (state_reg == jes_pkg::ST_P_RDP) vp_reg <= p_rd;
        if (state_reg == jes_pkg::ST_P_RDQ) vq_reg <= p_rd;
        if (state_reg == jes_pkg::ST_A_RDP) vp_reg <= a_rd;
        if (state_reg == jes_pkg::ST_A_RDQ) vq_reg <= a_rd;

        if (mac_v_reg) begin
            unique case (term_d_reg.dst)
                jes_pkg::DST_NONE: acc_reg <= sum;
                jes_pkg::DST_CC:   cc_reg  <= sum[31:0];
                jes_pkg::DST_SS:   ss_reg  <= sum[31:0];
                jes_pkg::DST_SC:   sc_reg  <= sum[31:0];
                jes_pkg::DST_R1:   r1_reg  <= jes_pkg::sat32(sum);
                jes_pkg::DST_R2:   r2_reg  <= jes_pkg::sat32(sum);
                jes_pkg::DST_DPP:  dpp_reg <= jes_pkg::sat32(sum);
                jes_pkg::DST_DQQ:  dqq_reg <= jes_pkg::sat32(sum);
                jes_pkg::DST_DPQ:  dpq_reg <= jes_pkg::sat32(sum);
                default: ;
            endcase
        end

        if (state_reg == jes_pkg::ST_P_WR) begin
            p_reg[k_reg][bp_reg] <= r1_reg;
            p_reg[k_reg][bq_reg] <= r2_reg;
        end

        if (state_reg == jes_pkg::ST_A_WR) begin
            a_reg[k_reg][bp_reg] <= r1_reg;
            a_reg[bp_reg][k_reg] <= r1_reg;
            a_reg[k_reg][bq_reg] <= r2_reg;
            a_reg[bq_reg][k_reg] <= r2_reg;
        end

        if (state_reg == jes_pkg::ST_DIAG_WR) begin
            a_reg[bp_reg][bp_reg] <= dpp_reg;
            a_reg[bq_reg][bq_reg] <= dqq_reg;
            a_reg[bp_reg][bq_reg] <= dpq_reg;
            a_reg[bq_reg][bp_reg] <= dpq_reg;
        end

        if (state_reg == jes_pkg::ST_OUT_LD) begin
            m_data_reg <= {2'b00, rot_reg, p_rd, a_rd, 3'(oj_reg), 3'(oi_reg)};
            m_last_reg <= (oi_reg == IW'(N - 1)) && (oj_reg == IW'(N - 1));
        end
    end

    assign s_tready = (state_reg == jes_pkg::ST_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== tb/sv/jes_checker.sv =====
`timescale 1ns / 1ps
// Checker for jacobi_eigen_solver: watches config writes and both stream channels,
// predicts eigen pairs in fixed point and compares each result beat. Uses jes_pkg.
module jes_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [jes_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [jes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jes_pkg::CFG_W-1:0]     cfg_wr_data,
    output int                            fail_count,
    output int                            pending
);
    import jes_pkg::*;

    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint HALF_Q30  = 64'sd536870912;
    localparam longint GAIN_Q30  = 64'sd652032874;
    localparam longint PI4_Q30   = 64'sd843314857;

    typedef struct {
        logic [2:0]  pair_index;
        logic [2:0]  component_index;
        logic [31:0] eigenvalue;
        logic [31:0] vector_component;
        logic [15:0] rotation_count;
        logic        last_result;
    } eigen_beat_t;

    eigen_beat_t eigen_q[$];

    longint      mat_a [N][N];
    longint      rot_v [N][N];
    int unsigned fill_pos;
    logic [30:0] tol_reg;
    logic [15:0] maxrot_reg;

    function automatic longint sat_w(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint x, input longint y);
        return (x * y + HALF_Q30) >>> 30;
    endfunction

    function automatic longint absv(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    function automatic longint vector_angle(input longint xi, input longint yi);
        longint x, y, z, dx, dy, t;
        x = xi; y = yi; z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            t  = longint'(signed'({1'b0, ATAN_TABLE[i & 31]}));
            if (y >= 0) begin
                x += dx; y -= dy; z += t;
            end else begin
                x -= dx; y += dy; z -= t;
            end
        end
        return z;
    endfunction

    task automatic sin_cos(input longint zi, output longint c, output longint s);
        longint x, y, z, dx, dy, t;
        x = GAIN_Q30; y = 0; z = zi;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            t  = longint'(signed'({1'b0, ATAN_TABLE[i & 31]}));
            if (z >= 0) begin
                x -= dx; y += dy; z -= t;
            end else begin
                x += dx; y -= dy; z += t;
            end
        end
        c = clamp_unit(x);
        s = clamp_unit(y);
    endtask

    task automatic largest_offdiag(output longint best, output int p, output int q);
        best = mat_a[0][1]; p = 0; q = 1;
        for (int i = 0; i < N; i++)
            for (int j = i + 1; j < N; j++)
                if (absv(mat_a[i][j]) > absv(best)) begin
                    best = mat_a[i][j]; p = i; q = j;
                end
    endtask

    task automatic apply_rotation(input int p, input int q, input longint apq);
        longint num, app, aqq, den, c, s, cq, sq, cc, ss, sc, z, vp, vq;
        longint row_p [N];
        longint row_q [N];
        num = 2 * apq;
        app = mat_a[p][p];
        aqq = mat_a[q][q];
        den = app - aqq;
        if (den == 0) begin
            sin_cos(PI4_Q30, cq, sq);
            if (num > 0) begin
                c = cq; s = sq;
            end else begin
                c = -sq; s = cq;
            end
        end else begin
            z = den > 0 ? vector_angle(den, num) : vector_angle(-den, -num);
            sin_cos(z >>> 1, c, s);
        end
        for (int k = 0; k < N; k++) begin
            vp = rot_v[k][p]; vq = rot_v[k][q];
            row_p[k] = sat_w(qmul(c, vp) + qmul(s, vq));
            row_q[k] = sat_w(qmul(-s, vp) + qmul(c, vq));
        end
        for (int k = 0; k < N; k++) begin
            rot_v[k][p] = row_p[k];
            rot_v[k][q] = row_q[k];
        end
        for (int k = 0; k < N; k++)
            if (k != p && k != q) begin
                vp = mat_a[k][p]; vq = mat_a[k][q];
                row_p[k] = sat_w(qmul(c, vp) + qmul(s, vq));
                row_q[k] = sat_w(qmul(-s, vp) + qmul(c, vq));
            end
        cc = qmul(c, c);
        ss = qmul(s, s);
        sc = qmul(s, c);
        row_p[p] = sat_w(qmul(cc, app) + qmul(2 * sc, apq) + qmul(ss, aqq));
        row_q[q] = sat_w(qmul(ss, app) - qmul(2 * sc, apq) + qmul(cc, aqq));
        row_p[q] = sat_w(qmul(cc - ss, apq) + qmul(sc, aqq - app));
        row_q[p] = row_p[q];
        for (int k = 0; k < N; k++) begin
            mat_a[p][k] = row_p[k];
            mat_a[k][p] = row_p[k];
            mat_a[q][k] = row_q[k];
            mat_a[k][q] = row_q[k];
        end
    endtask

    task automatic solve_and_queue();
        longint      apq;
        int          p, q;
        int unsigned done;
        eigen_beat_t b;
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                rot_v[i][j] = (i == j) ? ONE_Q30 : 0;
        done = 0;
        largest_offdiag(apq, p, q);
        while (absv(apq) > longint'(tol_reg) && done < maxrot_reg) begin
            apply_rotation(p, q, apq);
            largest_offdiag(apq, p, q);
            done++;
        end
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
                b.pair_index       = 3'(i);
                b.component_index  = 3'(j);
                b.eigenvalue       = mat_a[i][i][31:0];
                b.vector_component = rot_v[j][i][31:0];
                b.rotation_count   = 16'(done);
                b.last_result      = (i == N - 1 && j == N - 1);
                eigen_q.push_back(b);
            end
    endtask

    task automatic compare_result();
        eigen_beat_t e;
        if (eigen_q.size() == 0) begin
            $error("result beat with nothing expected: tdata=%h tlast=%b", m_tdata, m_tlast);
            fail_count++;
            return;
        end
        e = eigen_q.pop_front();
        if (m_tdata[2:0] !== e.pair_index) begin
            $error("pair_index: expected %0d, got %0d", e.pair_index, m_tdata[2:0]);
            fail_count++;
        end
        if (m_tdata[5:3] !== e.component_index) begin
            $error("component_index: expected %0d, got %0d", e.component_index, m_tdata[5:3]);
            fail_count++;
        end
        if (m_tdata[37:6] !== e.eigenvalue) begin
            $error("eigenvalue: expected %h, got %h", e.eigenvalue, m_tdata[37:6]);
            fail_count++;
        end
        if (m_tdata[69:38] !== e.vector_component) begin
            $error("vector_component: expected %h, got %h",
                   e.vector_component, m_tdata[69:38]);
            fail_count++;
        end
        if (m_tdata[85:70] !== e.rotation_count) begin
            $error("rotation_count: expected %0d, got %0d", e.rotation_count, m_tdata[85:70]);
            fail_count++;
        end
        if (m_tlast !== e.last_result) begin
            $error("last_result: expected %b, got %b", e.last_result, m_tlast);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            eigen_q.delete();
            fill_pos   = 0;
            tol_reg    = TOL_RESET;
            maxrot_reg = MAXR_RESET;
            for (int i = 0; i < N; i++)
                for (int j = 0; j < N; j++) begin
                    mat_a[i][j] = 0;
                    rot_v[i][j] = 0;
                end
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_TOLERANCE) tol_reg = cfg_wr_data[30:0];
                else if (cfg_index == CFG_MAX_ROT) maxrot_reg = cfg_wr_data[15:0];
            end
            if (s_tvalid && s_tready) begin
                if (fill_pos < N * N) begin
                    mat_a[fill_pos / N][fill_pos % N] = longint'(signed'(s_tdata));
                    fill_pos++;
                end
                if (s_tlast) begin
                    fill_pos = 0;
                    solve_and_queue();
                end
            end
            if (m_tvalid && m_tready) compare_result();
        end
        pending = eigen_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the jacobi_eigen_solver testbench: clock, reset, matrix loads, config phases
// and the verdict. Depends on jes_pkg, jacobi_eigen_solver and jes_checker.
module tb_top;
    import jes_pkg::*;

    localparam int TARGET_BEATS = 410;
    localparam int CYCLE_LIMIT  = 3000000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;    // entry_value
    logic                 s_tlast;    // last_entry
    logic                 m_tvalid;
    logic                 m_tready;
    // pair_index, component_index, eigenvalue, vector_component, rotation_count
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;    // last_result
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    int                   fail_count;
    int                   pending;

    logic [31:0] entries [N*N];
    int          beats_sent;
    int          cycle_count;
    int          stall_left;
    bit          calm_in;
    bit          calm_out;

    jacobi_eigen_solver u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    jes_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if ($urandom_range(0, 399) == 0) calm_out <= ~calm_out;
            if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready   <= 1'b1;
                stall_left <= pick_gap(calm_out);
            end
        end
    end

    task automatic send_beat(input logic [31:0] d, input logic l);
        int gap;
        if ($urandom_range(0, 199) == 0) calm_in = ~calm_in;
        gap = pick_gap(calm_in);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        beats_sent++;
    endtask

    // count < N*N leaves the tail of the store as is; extra beats past N*N are dropped
    task automatic load_matrix(input int count);
        for (int i = 0; i < count; i++)
            send_beat(i < N*N ? entries[i] : $urandom(), i == count - 1);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic set_config(input logic [30:0] tol, input logic [15:0] maxr);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_TOLERANCE;
        cfg_wr_data <= tol;
        @(negedge aclk);
        cfg_index   <= CFG_MAX_ROT;
        cfg_wr_data <= CFG_W'(maxr);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // kind: 0 modest symmetric, 1 full-range symmetric, 2 full-range arbitrary,
    // 3 modest symmetric with equal diagonal
    task automatic fill_entries(input int kind);
        logic [31:0] d;
        d = $urandom_range(0, 2**20) - 2**19;
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                if (kind == 1 || kind == 2) entries[i*N+j] = $urandom();
                else entries[i*N+j] = $urandom_range(0, 2**21) - 2**20;
        if (kind != 2)
            for (int i = 0; i < N; i++)
                for (int j = 0; j < i; j++)
                    entries[i*N+j] = entries[j*N+i];
        if (kind == 3)
            for (int i = 0; i < N; i++) entries[i*N+i] = d;
    endtask

    task automatic clear_matrix();
        for (int i = 0; i < N*N; i++) entries[i] = '0;
    endtask

    initial begin
        int len, kind, phase;
        logic [30:0] tol;
        logic [15:0] maxr;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_TOLERANCE;
        cfg_wr_data = '0;
        beats_sent  = 0;
        cycle_count = 0;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        set_config(31'd1, 16'd40);
        // extreme entries, full load first so the whole store is written
        fill_entries(1);
        entries[0] = 32'h7FFF_FFFF; entries[5] = 32'h8000_0000;
        entries[1] = 32'h8000_0000; entries[4] = 32'h8000_0000;
        entries[2] = 32'hFFFF_FFFF; entries[8] = 32'hFFFF_FFFF;
        load_matrix(N*N);
        // equal diagonal, positive off-diagonal: quarter-pi angle
        clear_matrix();
        entries[0] = 32'h0003_0000; entries[5] = 32'h0003_0000;
        entries[1] = 32'h0001_0000; entries[4] = 32'h0001_0000;
        load_matrix(N*N);
        // equal diagonal, negative off-diagonal: three-quarter-pi angle
        entries[1] = 32'hFFFF_0000; entries[4] = 32'hFFFF_0000;
        load_matrix(N*N);
        // already diagonal: no rotation
        clear_matrix();
        entries[0] = 32'h0001_0000; entries[15] = 32'hFFFE_0000;
        load_matrix(N*N);
        // short load over the previous content, then an overlong non-symmetric load
        entries[0] = 32'h0000_8000; entries[1] = 32'h0000_4000; entries[2] = 32'h7FFF_FFFF;
        load_matrix(3);
        fill_entries(2);
        load_matrix(N*N + 3);
        drain_results();

        set_config(31'd1, 16'd0);
        fill_entries(0);
        load_matrix(N*N);
        drain_results();

        set_config(31'h7FFF_FFFF, 16'd65535);
        clear_matrix();
        entries[1] = 32'h8000_0000; entries[4] = 32'h8000_0000;
        load_matrix(N*N);
        drain_results();

        phase = 0;
        while (beats_sent < TARGET_BEATS) begin
            case (phase % 5)
                0: begin tol = 31'd1; maxr = 16'd40; end
                1: begin tol = 31'd0; maxr = 16'd1; end
                2: begin tol = 31'd0; maxr = 16'd12; end
                3: begin
                    tol  = 31'($urandom_range(0, 2**24));
                    maxr = 16'($urandom_range(2, 60));
                end
                default: begin tol = 31'h7FFF_FFFF; maxr = 16'd65535; end
            endcase
            set_config(tol, maxr);
            repeat (3) begin
                // under the widest limits only modest full loads: stale full-range
                // content could keep rotating close to the limit
                kind = (phase % 5 == 4) ? 0 : $urandom_range(0, 3);
                fill_entries(kind);
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(1, N*N - 1);
                    1: len = $urandom_range(N*N + 1, N*N + 4);
                    default: len = N*N;
                endcase
                if (phase % 5 == 4) len = N*N;
                load_matrix(len);
            end
            drain_results();
            phase++;
        end

        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/jes_pkg.sv
hdl/jes_cordic.sv
hdl/jacobi_eigen_solver.sv
tb/sv/jes_checker.sv
tb/sv/tb_top.sv
